// File: rtl/mrac_pkg.sv
package mrac_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DENIED    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } ctl_state_t;

  // Control part of the query token that walks down the cell row.
  typedef struct packed {
    logic valid;
    logic kill;   // already resolved before the walk, cells ignore it
    op_t  op;
    logic found;  // some earlier cell took the word
    logic grant;  // permissions of the found region cover the request
  } tok_ctl_t;

endpackage

// File: rtl/mrac_if.sv
interface mrac_cmd_if #(
  parameter int ADDR_BITS = 32,
  parameter int PERM_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [ADDR_BITS-1:0] address;
  logic [ADDR_BITS-1:0] length;
  logic [PERM_BITS-1:0] perm_bits;

  modport source (output valid, opcode, address, length, perm_bits, input ready);
  modport sink   (input valid, opcode, address, length, perm_bits, output ready);
endinterface

interface mrac_rsp_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [CNT_W-1:0] regions_held;

  modport source (output valid, status, regions_held, input ready);
  modport sink   (input valid, status, regions_held, output ready);
endinterface

// File: rtl/mrac_cell.sv
module mrac_cell
  import mrac_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 32,
  parameter int PERM_BITS   = 8,
  parameter int IDX         = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [$clog2(MAX_REGIONS+1)-1:0]       count,
  input  tok_ctl_t                               tin_ctl,
  input  logic [ADDR_BITS-1:0]                   tin_addr,
  input  logic [ADDR_BITS:0]                     tin_aend,
  input  logic [PERM_BITS-1:0]                   tin_perm,
  output tok_ctl_t                               tout_ctl,
  output logic [ADDR_BITS-1:0]                   tout_addr,
  output logic [ADDR_BITS:0]                     tout_aend,
  output logic [PERM_BITS-1:0]                   tout_perm,
  input  logic [ADDR_BITS-1:0]                   nb_base,
  input  logic [ADDR_BITS:0]                     nb_rend,
  input  logic [PERM_BITS-1:0]                   nb_perms,
  output logic [ADDR_BITS-1:0]                   base,
  output logic [ADDR_BITS:0]                     rend,
  output logic [PERM_BITS-1:0]                   perms
);

  localparam int CNT_W = $clog2(MAX_REGIONS+1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic     live;
  logic     occupied;
  logic     add_hit;
  logic     rm_hit;
  logic     ck_hit;
  logic     shift;
  tok_ctl_t ctl_next;

  assign live     = tin_ctl.valid && !tin_ctl.kill && !tin_ctl.found;
  assign occupied = MY_IDX < count;
  assign add_hit  = live && (tin_ctl.op == OP_ADD) && (MY_IDX == count);
  assign rm_hit   = live && (tin_ctl.op == OP_REMOVE) && occupied && (base == tin_addr);
  assign ck_hit   = live && (tin_ctl.op == OP_CHECK) && occupied &&
                    (tin_addr >= base) && (tin_aend <= rend);
  // Close the gap: once the removed region lies at or behind this cell, pull from the right.
  assign shift    = tout_ctl.valid && !tout_ctl.kill && (tout_ctl.op == OP_REMOVE) &&
                    tout_ctl.found;

  always_comb begin
    ctl_next = tin_ctl;
    if (add_hit || rm_hit || ck_hit) begin
      ctl_next.found = 1'b1;
    end
    if (ck_hit) begin
      ctl_next.grant = ((perms & tin_perm) == tin_perm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_ctl <= '0;
    end else begin
      tout_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    tout_addr <= tin_addr;
    tout_aend <= tin_aend;
    tout_perm <= tin_perm;
  end

  always_ff @(posedge clk) begin
    if (add_hit) begin
      base  <= tin_addr;
      rend  <= tin_aend;
      perms <= tin_perm;
    end else if (shift) begin
      base  <= nb_base;
      rend  <= nb_rend;
      perms <= nb_perms;
    end
  end

endmodule

// File: rtl/memory_region_access_checker.sv
// Channel   Dir  Fields                                   Handshake
// cmd       in   opcode, address, length, perm_bits       valid/ready
// rsp       out  status, regions_held                     valid/ready
// cfg       in   cfg_wdata (sandbox_active)               cfg_we, no wait
//
// One query token walks the row of MAX_REGIONS cells, one cell a cycle; each
// cell holds one region and tests, appends or shifts as the token passes.
// A new item is accepted only after the previous token has left the row.
// A result waiting in the output register does not stop the next word; if the
// next result arrives before it drains, park it and hold cmd.ready low.
// Synchronous reset empties the table and sets sandbox_active.
module memory_region_access_checker
  import mrac_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 32,
  parameter int PERM_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  mrac_cmd_if.sink    cmd,
  mrac_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_REGIONS+1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_REGIONS);

  ctl_state_t state, state_next;

  logic             active;
  logic [CNT_W-1:0] count;

  // Token chain: index 0 is the launch register, index k+1 leaves cell k.
  tok_ctl_t             t_ctl  [0:MAX_REGIONS];
  logic [ADDR_BITS-1:0] t_addr [0:MAX_REGIONS];
  logic [ADDR_BITS:0]   t_aend [0:MAX_REGIONS];
  logic [PERM_BITS-1:0] t_perm [0:MAX_REGIONS];

  logic [ADDR_BITS-1:0] c_base  [0:MAX_REGIONS-1];
  logic [ADDR_BITS:0]   c_rend  [0:MAX_REGIONS-1];
  logic [PERM_BITS-1:0] c_perms [0:MAX_REGIONS-1];

  logic       accept;
  logic       kill;
  status_t    early;
  status_t    estat;
  logic       exit_now;
  status_t    fin_status;
  logic [CNT_W-1:0] fin_count;
  logic       out_free;
  logic       load_out;
  logic       capture_hold;
  status_t    hold_status;
  logic [CNT_W-1:0] hold_count;
  logic       out_valid;
  status_t    out_status;
  logic [CNT_W-1:0] out_count;
  tok_ctl_t   launch_next;

  assign accept   = cmd.valid && cmd.ready;
  assign exit_now = t_ctl[MAX_REGIONS].valid;
  assign out_free = !out_valid || rsp.ready;

  // Sandbox enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
    end else if (cfg_we) begin
      active <= cfg_wdata;
    end
  end

  // Resolve everything that does not need the table before the walk.
  always_comb begin
    kill  = 1'b1;
    early = ST_INVALID;
    if (active) begin
      unique case (cmd.opcode)
        OP_ADD: begin
          if (count >= FULL) begin
            early = ST_NO_SPACE;
          end else if (cmd.address != '0 && cmd.length != '0) begin
            kill = 1'b0;
          end
        end
        OP_REMOVE: begin
          kill = (cmd.address == '0);
        end
        OP_CHECK: begin
          kill = (cmd.address == '0) || (cmd.length == '0);
        end
        default: begin
          kill = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    launch_next       = '0;
    launch_next.valid = accept;
    launch_next.kill  = kill;
    launch_next.op    = op_t'(cmd.opcode);
  end

  // Launch register feeds cell 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_ctl[0] <= '0;
    end else begin
      t_ctl[0] <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_addr[0] <= cmd.address;
      t_aend[0] <= {1'b0, cmd.address} + {1'b0, cmd.length};
      t_perm[0] <= cmd.perm_bits;
      estat     <= early;
    end
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    logic [ADDR_BITS-1:0] nb_base;
    logic [ADDR_BITS:0]   nb_rend;
    logic [PERM_BITS-1:0] nb_perms;

    if (i == MAX_REGIONS-1) begin : g_last
      // Nothing to the right: the last entry falls out of the count.
      assign nb_base  = c_base[i];
      assign nb_rend  = c_rend[i];
      assign nb_perms = c_perms[i];
    end else begin : g_mid
      assign nb_base  = c_base[i+1];
      assign nb_rend  = c_rend[i+1];
      assign nb_perms = c_perms[i+1];
    end

    mrac_cell #(
      .MAX_REGIONS (MAX_REGIONS),
      .ADDR_BITS   (ADDR_BITS),
      .PERM_BITS   (PERM_BITS),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .tin_ctl   (t_ctl[i]),
      .tin_addr  (t_addr[i]),
      .tin_aend  (t_aend[i]),
      .tin_perm  (t_perm[i]),
      .tout_ctl  (t_ctl[i+1]),
      .tout_addr (t_addr[i+1]),
      .tout_aend (t_aend[i+1]),
      .tout_perm (t_perm[i+1]),
      .nb_base   (nb_base),
      .nb_rend   (nb_rend),
      .nb_perms  (nb_perms),
      .base      (c_base[i]),
      .rend      (c_rend[i]),
      .perms     (c_perms[i])
    );
  end

  // Turn the token that leaves the row into a status and the new count.
  always_comb begin
    fin_status = estat;
    fin_count  = count;
    if (!t_ctl[MAX_REGIONS].kill) begin
      unique case (t_ctl[MAX_REGIONS].op)
        OP_ADD: begin
          fin_status = ST_OK;
          fin_count  = count + CNT_W'(1);
        end
        OP_REMOVE: begin
          if (t_ctl[MAX_REGIONS].found) begin
            fin_status = ST_OK;
            fin_count  = count - CNT_W'(1);
          end else begin
            fin_status = ST_NOT_FOUND;
          end
        end
        OP_CHECK: begin
          fin_status = (t_ctl[MAX_REGIONS].found && t_ctl[MAX_REGIONS].grant) ?
                       ST_OK : ST_DENIED;
        end
        default: begin
          fin_status = ST_INVALID;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (exit_now) begin
          state_next = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    cmd.ready    = 1'b0;
    load_out     = 1'b0;
    capture_hold = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
      end
      S_RUN: begin
        load_out     = exit_now && out_free;
        capture_hold = exit_now && !out_free;
      end
      S_HOLD: begin
        load_out = out_free;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (exit_now) begin
        count <= fin_count;
      end
    end
  end

  // Park the result while the output register is still occupied.
  always_ff @(posedge clk) begin
    if (capture_hold) begin
      hold_status <= fin_status;
      hold_count  <= fin_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= (state == S_HOLD) ? hold_status : fin_status;
      out_count  <= (state == S_HOLD) ? hold_count : fin_count;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.regions_held = out_count;

endmodule
